// ===== sv/bis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants and types of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int COORD_W  = 12;   // col / row fields
    localparam int PIX_W    = 8;    // gray value
    localparam int SIZE_W   = 10;   // source_width / source_height
    localparam int STEP_W   = 20;   // Q4.16 step
    localparam int FRAC_W   = 16;   // fraction bits of a position
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_REQ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_STEP_X     = 2'd2,
        CFG_STEP_Y     = 2'd3
    } t_cfg_idx;

endpackage
`default_nettype wire

// ===== sv/bis_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bis_front
// Accepts items, maps request coordinates to source index, weights and
// frame store address, and hands finished jobs to the queue.
// ----------------------------------------------------------------------------
module bis_front #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int WEIGHT_BITS    = 11,
    parameter int AW             = 18,
    parameter int JW             = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_cmd,
    input  wire logic [bis_pkg::COORD_W-1:0]   i_col,
    input  wire logic [bis_pkg::COORD_W-1:0]   i_row,
    input  wire logic [bis_pkg::PIX_W-1:0]     i_pixel_in,
    input  wire logic [bis_pkg::SIZE_W-1:0]    i_src_width,
    input  wire logic [bis_pkg::SIZE_W-1:0]    i_src_height,
    input  wire logic [bis_pkg::STEP_W-1:0]    i_step_x,
    input  wire logic [bis_pkg::STEP_W-1:0]    i_step_y,
    output logic                               o_push,
    output logic [JW-1:0]                      o_job,
    input  wire logic                          i_full
);

    localparam int CW   = (MAX_SRC_WIDTH  > 1) ? $clog2(MAX_SRC_WIDTH)  : 1;
    localparam int RW   = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int WB1  = WEIGHT_BITS + 1;
    localparam int WW   = 2 * WEIGHT_BITS + 1;
    localparam int SH   = bis_pkg::FRAC_W - WEIGHT_BITS;
    localparam int PW   = bis_pkg::COORD_W + 1 + bis_pkg::STEP_W;  // (2d+1)*step
    localparam int IBW  = PW - bis_pkg::FRAC_W;                    // floor(pos)+1
    localparam int ONE  = 1 << WEIGHT_BITS;

    // clamp index to [0, size-2], size itself clamped to [2, maxsize]
    function automatic logic [IBW-1:0] clamp_idx(input logic [IBW-1:0] ib,
                                                 input logic [bis_pkg::SIZE_W-1:0] size,
                                                 input logic [13:0] maxsize);
        logic [13:0]    sz;
        logic [IBW-1:0] idx;
        logic [IBW-1:0] lim;
        sz = {4'd0, size};
        if (sz < 14'd2) sz = 14'd2;
        if (sz > maxsize) sz = maxsize;
        lim = IBW'(sz - 14'd2);
        idx = (ib == '0) ? '0 : ib - IBW'(1);
        if (idx > lim) idx = lim;
        return idx;
    endfunction

    function automatic logic [WB1-1:0] weight0(input logic [bis_pkg::FRAC_W-1:0] frac);
        logic [16:0] w;
        w = (17'd65536 - {1'b0, frac} + 17'(1 << (SH - 1))) >> SH;
        if (w > 17'(ONE)) w = 17'(ONE);
        return w[WB1-1:0];
    endfunction

    logic en;
    logic accept;

    // stage 1: products
    logic                          r1_v;
    logic                          r1_cmd;
    logic [bis_pkg::COORD_W-1:0]   r1_col, r1_row;
    logic [bis_pkg::PIX_W-1:0]     r1_pix;
    logic [PW-1:0]                 r1_px, r1_py;

    // stage 2: index and weights
    logic                          r2_v;
    logic                          r2_cmd, r2_wr_ok;
    logic [CW-1:0]                 r2_ax;
    logic [RW-1:0]                 r2_ay;
    logic [WB1-1:0]                r2_wx0, r2_wx1, r2_wy0, r2_wy1;
    logic [bis_pkg::COORD_W-1:0]   r2_col, r2_row;
    logic [bis_pkg::PIX_W-1:0]     r2_pix;

    // stage 3: address and weight products
    logic                          r3_v;
    logic                          r3_cmd, r3_wr_ok;
    logic [AW-1:0]                 r3_addr;
    logic [4*WW-1:0]               r3_wxy;
    logic [bis_pkg::COORD_W-1:0]   r3_col, r3_row;
    logic [bis_pkg::PIX_W-1:0]     r3_pix;

    logic [PW:0]          bx, by;
    logic [IBW-1:0]       ix, iy;
    logic [WB1-1:0]       wx0, wy0;
    logic                 wr_ok;

    assign en         = !(r3_v && i_full);
    assign o_in_ready = en;
    assign accept     = i_in_valid && en;

    always_comb begin
        // position + 1.0, Q.16, halved
        bx    = ({1'b0, r1_px} + (PW+1)'(65536)) >> 1;
        by    = ({1'b0, r1_py} + (PW+1)'(65536)) >> 1;
        ix    = clamp_idx(bx[PW-1:bis_pkg::FRAC_W], i_src_width, 14'(MAX_SRC_WIDTH));
        iy    = clamp_idx(by[PW-1:bis_pkg::FRAC_W], i_src_height, 14'(MAX_SRC_HEIGHT));
        wx0   = weight0(bx[bis_pkg::FRAC_W-1:0]);
        wy0   = weight0(by[bis_pkg::FRAC_W-1:0]);
        wr_ok = ({1'b0, r1_col} < 13'(MAX_SRC_WIDTH)) &&
                ({1'b0, r1_row} < 13'(MAX_SRC_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd <= i_cmd;
            r1_col <= i_col;
            r1_row <= i_row;
            r1_pix <= i_pixel_in;
            r1_px  <= PW'({i_col, 1'b1}) * PW'(i_step_x);
            r1_py  <= PW'({i_row, 1'b1}) * PW'(i_step_y);

            r2_cmd   <= r1_cmd;
            r2_wr_ok <= wr_ok;
            r2_ax    <= (r1_cmd == bis_pkg::CMD_REQ) ? ix[CW-1:0] : r1_col[CW-1:0];
            r2_ay    <= (r1_cmd == bis_pkg::CMD_REQ) ? iy[RW-1:0] : r1_row[RW-1:0];
            r2_wx0   <= wx0;
            r2_wx1   <= WB1'(ONE) - wx0;
            r2_wy0   <= wy0;
            r2_wy1   <= WB1'(ONE) - wy0;
            r2_col   <= r1_col;
            r2_row   <= r1_row;
            r2_pix   <= r1_pix;

            r3_cmd   <= r2_cmd;
            r3_wr_ok <= r2_wr_ok;
            r3_addr  <= AW'(AW'(r2_ay) * AW'(MAX_SRC_WIDTH) + AW'(r2_ax));
            r3_wxy   <= {WW'(r2_wx1) * WW'(r2_wy1), WW'(r2_wx1) * WW'(r2_wy0),
                         WW'(r2_wx0) * WW'(r2_wy1), WW'(r2_wx0) * WW'(r2_wy0)};
            r3_col   <= r2_col;
            r3_row   <= r2_row;
            r3_pix   <= r2_pix;
        end
    end

    assign o_push = r3_v && !i_full;
    assign o_job  = {r3_cmd, r3_wr_ok, r3_addr, r3_wxy, r3_col, r3_row, r3_pix};

endmodule
`default_nettype wire

// ===== sv/bis_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bis_fifo
// Four-entry show-ahead job queue between front and back.
// ----------------------------------------------------------------------------
module bis_fifo #(
    parameter int JW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [JW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic [JW-1:0]      o_data
);

    logic [JW-1:0] r_mem [4];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_cnt;
    logic          do_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (do_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

// ===== sv/bis_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bis_back
// Frame store, four-read sequencer per request, multiply-accumulate blend
// and output register.
// ----------------------------------------------------------------------------
module bis_back #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int WEIGHT_BITS    = 11,
    parameter int AW             = 18,
    parameter int JW             = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_job_valid,
    input  wire logic [JW-1:0]                 i_job,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [bis_pkg::PIX_W-1:0]          o_out_pixel,
    output logic [bis_pkg::COORD_W-1:0]        o_out_col,
    output logic [bis_pkg::COORD_W-1:0]        o_out_row
);

    localparam int WW    = 2 * WEIGHT_BITS + 1;
    localparam int AC    = 2 * WEIGHT_BITS + bis_pkg::PIX_W;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int CRW   = bis_pkg::COORD_W;

    logic [bis_pkg::PIX_W-1:0] mem [DEPTH];

    logic          en;
    logic          r_cur_v;
    logic [JW-1:0] r_cur;
    logic [1:0]    r_phase;

    logic          cur_cmd, cur_wr_ok;
    logic [AW-1:0] cur_addr;
    logic [4*WW-1:0] cur_wxy;
    logic [CRW-1:0] cur_col, cur_row;
    logic [bis_pkg::PIX_W-1:0] cur_pix;

    logic          done_now, take, we, rd_v;
    logic [AW-1:0] addr, offs;

    // read stage
    logic                  r1_v, r1_first, r1_last;
    logic [WW-1:0]         r1_w;
    logic [CRW-1:0]        r1_col, r1_row;
    logic [bis_pkg::PIX_W-1:0] r1_data;
    // product stage
    logic                  r2_v, r2_first, r2_last;
    logic [AC-1:0]         r2_prod;
    logic [CRW-1:0]        r2_col, r2_row;
    // accumulate
    logic [AC-1:0]         r_acc, sum;
    logic                  r_out_v;

    assign {cur_cmd, cur_wr_ok, cur_addr, cur_wxy, cur_col, cur_row, cur_pix} = r_cur;

    // whole back end advances unless a finished result is still waiting
    assign en       = !r_out_v || i_out_ready;
    assign done_now = r_cur_v && (cur_cmd == bis_pkg::CMD_LOAD || r_phase == 2'd3);
    assign take     = en && (!r_cur_v || done_now);
    assign o_pop    = take;
    assign we       = r_cur_v && cur_cmd == bis_pkg::CMD_LOAD && cur_wr_ok;
    assign rd_v     = r_cur_v && cur_cmd == bis_pkg::CMD_REQ;

    always_comb begin
        case (r_phase)
            2'd0:    offs = '0;
            2'd1:    offs = AW'(MAX_SRC_WIDTH);
            2'd2:    offs = AW'(1);
            default: offs = AW'(MAX_SRC_WIDTH + 1);
        endcase
        addr = (cur_cmd == bis_pkg::CMD_REQ) ? cur_addr + offs : cur_addr;
        sum  = r2_first ? r2_prod : r_acc + r2_prod;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (we) mem[addr] <= cur_pix;
            r1_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v <= 1'b0;
            r_phase <= '0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            if (take) begin
                r_cur_v <= i_job_valid;
                r_phase <= '0;
            end else begin
                r_phase <= r_phase + 2'd1;
            end
            r1_v    <= rd_v;
            r2_v    <= r1_v;
            r_out_v <= r2_v && r2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_cur <= i_job;
        if (en) begin
            r1_first <= (r_phase == 2'd0);
            r1_last  <= (r_phase == 2'd3);
            r1_w     <= cur_wxy[r_phase*WW +: WW];
            r1_col   <= cur_col;
            r1_row   <= cur_row;

            r2_first <= r1_first;
            r2_last  <= r1_last;
            r2_prod  <= AC'(r1_data) * AC'(r1_w);
            r2_col   <= r1_col;
            r2_row   <= r1_row;

            if (r2_v) r_acc <= sum;
            if (r2_v && r2_last) begin
                o_out_pixel <= sum[AC-1 -: bis_pkg::PIX_W];
                o_out_col   <= r2_col;
                o_out_row   <= r2_row;
            end
        end
    end

    assign o_out_valid = r_out_v;

endmodule
`default_nettype wire

// ===== sv/bilinear_image_scaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Grayscale bilinear resizer with on-chip frame store.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       i_in_valid / o_in_ready   i_cmd, i_col, i_row, i_pixel_in
//  out      o_out_valid / i_out_ready o_out_pixel, o_out_col, o_out_row
//  cfg      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  A load takes one access of the single frame store port, a request four
//  (one read per neighbor), so a request holds the port until its last read.
//  Reset is synchronous; the frame store is not cleared.
//  A 4-entry queue lets the front keep taking items while the back stalls.
// ----------------------------------------------------------------------------
module bilinear_image_scaler #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int WEIGHT_BITS    = 11
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_cmd,
    input  wire logic [bis_pkg::COORD_W-1:0]       i_col,
    input  wire logic [bis_pkg::COORD_W-1:0]       i_row,
    input  wire logic [bis_pkg::PIX_W-1:0]         i_pixel_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [bis_pkg::PIX_W-1:0]              o_out_pixel,
    output logic [bis_pkg::COORD_W-1:0]            o_out_col,
    output logic [bis_pkg::COORD_W-1:0]            o_out_row,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bis_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
    localparam int WW = 2 * WEIGHT_BITS + 1;
    localparam int JW = 2 + AW + 4 * WW + 2 * bis_pkg::COORD_W + bis_pkg::PIX_W;

    logic [bis_pkg::SIZE_W-1:0] r_src_width, r_src_height;
    logic [bis_pkg::STEP_W-1:0] r_step_x, r_step_y;

    logic          push, full, pop, q_valid;
    logic [JW-1:0] job_in, job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= bis_pkg::SIZE_RESET;
            r_src_height <= bis_pkg::SIZE_RESET;
            r_step_x     <= bis_pkg::STEP_RESET;
            r_step_y     <= bis_pkg::STEP_RESET;
        end else if (i_cfg_valid) begin
            case (bis_pkg::t_cfg_idx'(i_cfg_index))
                bis_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[bis_pkg::SIZE_W-1:0];
                bis_pkg::CFG_STEP_X:     r_step_x     <= i_cfg_data;
                bis_pkg::CFG_STEP_Y:     r_step_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bis_front #(
        .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .AW            (AW),
        .JW            (JW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_pixel_in   (i_pixel_in),
        .i_src_width  (r_src_width),
        .i_src_height (r_src_height),
        .i_step_x     (r_step_x),
        .i_step_y     (r_step_y),
        .o_push       (push),
        .o_job        (job_in),
        .i_full       (full)
    );

    bis_fifo #(.JW(JW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (job_out)
    );

    bis_back #(
        .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .AW            (AW),
        .JW            (JW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_pixel (o_out_pixel),
        .o_out_col   (o_out_col),
        .o_out_row   (o_out_row)
    );

endmodule
`default_nettype wire

// ===== tb/bis_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bis_checker
// Watches the config, input and output channels of the bilinear image scaler,
// keeps a shadow frame store and registers, predicts every requested pixel and
// compares each output transaction field by field in order.
// ----------------------------------------------------------------------------
module bis_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic                           i_cmd,
    input  wire logic [bis_pkg::COORD_W-1:0]    i_col,
    input  wire logic [bis_pkg::COORD_W-1:0]    i_row,
    input  wire logic [bis_pkg::PIX_W-1:0]      i_pixel_in,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [bis_pkg::PIX_W-1:0]      i_out_pixel,
    input  wire logic [bis_pkg::COORD_W-1:0]    i_out_col,
    input  wire logic [bis_pkg::COORD_W-1:0]    i_out_row,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fails,
    output int                                  o_pending
);

    localparam int MAXW = 512;
    localparam int MAXH = 512;
    localparam int WB   = 11;

    typedef struct {
        logic [bis_pkg::PIX_W-1:0]   pix;
        logic [bis_pkg::COORD_W-1:0] col;
        logic [bis_pkg::COORD_W-1:0] row;
    } t_dst_pixel;

    logic [bis_pkg::PIX_W-1:0]  frame [0:MAXW*MAXH-1];
    logic [bis_pkg::SIZE_W-1:0] src_w, src_h;
    logic [bis_pkg::STEP_W-1:0] stp_x, stp_y;
    t_dst_pixel                 dst_q[$];
    int                         fails = 0;

    assign o_fails   = fails;
    assign o_pending = dst_q.size();

    // one axis: clamped left/top index and weight of that neighbor
    function automatic void map_axis(input logic [bis_pkg::COORD_W-1:0] d,
                                     input logic [bis_pkg::STEP_W-1:0] stp,
                                     input logic [bis_pkg::SIZE_W-1:0] size,
                                     input int maxsz,
                                     output int idx, output longint w0);
        longint biased, ib, frac, sz;
        biased = ((2 * longint'(d) + 1) * longint'(stp) + 65536) >>> 1;
        ib     = biased >>> 16;
        frac   = biased & 16'hFFFF;
        sz     = size;
        if (sz < 2) sz = 2;
        if (sz > maxsz) sz = maxsz;
        if (ib < 1) ib = 1;
        if (ib - 1 > sz - 2) ib = sz - 1;
        idx = int'(ib - 1);
        w0  = (65536 - frac + (1 << (15 - WB))) >>> (16 - WB);
        if (w0 > (1 << WB)) w0 = 1 << WB;
    endfunction

    function automatic logic [bis_pkg::PIX_W-1:0] blend(
            input logic [bis_pkg::COORD_W-1:0] c,
            input logic [bis_pkg::COORD_W-1:0] r);
        int     sx, sy;
        longint wx0, wy0, wx1, wy1, sum;
        map_axis(c, stp_x, src_w, MAXW, sx, wx0);
        map_axis(r, stp_y, src_h, MAXH, sy, wy0);
        wx1 = (1 << WB) - wx0;
        wy1 = (1 << WB) - wy0;
        sum = longint'(frame[sy*MAXW + sx]) * wx0 * wy0
            + longint'(frame[(sy+1)*MAXW + sx]) * wx0 * wy1
            + longint'(frame[sy*MAXW + sx + 1]) * wx1 * wy0
            + longint'(frame[(sy+1)*MAXW + sx + 1]) * wx1 * wy1;
        return bis_pkg::PIX_W'(sum >>> (2 * WB));
    endfunction

    always @(posedge i_clk) begin
        t_dst_pixel e;
        if (!i_rst_n) begin
            src_w = bis_pkg::SIZE_RESET;
            src_h = bis_pkg::SIZE_RESET;
            stp_x = bis_pkg::STEP_RESET;
            stp_y = bis_pkg::STEP_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (bis_pkg::t_cfg_idx'(i_cfg_index))
                    bis_pkg::CFG_SRC_WIDTH:  src_w = i_cfg_data[bis_pkg::SIZE_W-1:0];
                    bis_pkg::CFG_SRC_HEIGHT: src_h = i_cfg_data[bis_pkg::SIZE_W-1:0];
                    bis_pkg::CFG_STEP_X:     stp_x = i_cfg_data;
                    bis_pkg::CFG_STEP_Y:     stp_y = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_cmd == bis_pkg::CMD_LOAD) begin
                    if (i_col < MAXW && i_row < MAXH)
                        frame[int'(i_row)*MAXW + int'(i_col)] = i_pixel_in;
                end else begin
                    e.pix = blend(i_col, i_row);
                    e.col = i_col;
                    e.row = i_row;
                    dst_q.push_back(e);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (dst_q.size() == 0) begin
                    $display("%0t: unexpected output transaction pixel %0d col %0d row %0d",
                             $time, i_out_pixel, i_out_col, i_out_row);
                    fails++;
                end else begin
                    e = dst_q.pop_front();
                    if (i_out_pixel !== e.pix) begin
                        $display("%0t: out_pixel expected %0d actual %0d (col %0d row %0d)",
                                 $time, e.pix, i_out_pixel, e.col, e.row);
                        fails++;
                    end
                    if (i_out_col !== e.col) begin
                        $display("%0t: out_col expected %0d actual %0d",
                                 $time, e.col, i_out_col);
                        fails++;
                    end
                    if (i_out_row !== e.row) begin
                        $display("%0t: out_row expected %0d actual %0d",
                                 $time, e.row, i_out_row);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bilinear image scaler: loads source pixels, requests
// destination pixels over several size and step settings with random idling on
// both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAXW = 512;
    localparam int MAXH = 512;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           cmd = bis_pkg::CMD_LOAD;
    logic [bis_pkg::COORD_W-1:0]    col = '0;
    logic [bis_pkg::COORD_W-1:0]    row = '0;
    logic [bis_pkg::PIX_W-1:0]      pix = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [bis_pkg::PIX_W-1:0]      out_pixel;
    logic [bis_pkg::COORD_W-1:0]    out_col, out_row;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bis_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int                             fails, pending;

    bit                             written [0:MAXW*MAXH-1];
    logic [bis_pkg::SIZE_W-1:0]     cur_w = bis_pkg::SIZE_RESET;
    logic [bis_pkg::SIZE_W-1:0]     cur_h = bis_pkg::SIZE_RESET;
    logic [bis_pkg::STEP_W-1:0]     cur_sx = bis_pkg::STEP_RESET;
    logic [bis_pkg::STEP_W-1:0]     cur_sy = bis_pkg::STEP_RESET;
    int                             req_sent = 0, res_got = 0;
    bit                             calm = 1'b0;
    bit                             took = 1'b0;
    int                             stall = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    bilinear_image_scaler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_cmd(cmd), .i_col(col), .i_row(row), .i_pixel_in(pix),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_pixel(out_pixel), .o_out_col(out_col), .o_out_row(out_row),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    bis_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_cmd(cmd), .i_col(col), .i_row(row), .i_pixel_in(pix),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_pixel(out_pixel), .i_out_col(out_col), .i_out_row(out_row),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fails(fails), .o_pending(pending)
    );

    function automatic int gap_draw();
        if (calm || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    // receiver side: fresh stall after each output transaction
    always @(posedge i_clk) begin
        took <= out_valid && out_ready;
        if (i_rst_n && out_valid && out_ready) res_got++;
    end

    always @(negedge i_clk) begin
        if (took) stall = gap_draw();
        if (stall > 0) begin
            out_ready <= 1'b0;
            stall--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // clamped top/left source index of one axis, used to preload neighbors
    function automatic int src_index(input logic [bis_pkg::COORD_W-1:0] d,
                                     input logic [bis_pkg::STEP_W-1:0] stp,
                                     input logic [bis_pkg::SIZE_W-1:0] size,
                                     input int maxsz);
        longint ib, sz;
        ib = (((2 * longint'(d) + 1) * longint'(stp) + 65536) >>> 1) >>> 16;
        sz = size;
        if (sz < 2) sz = 2;
        if (sz > maxsz) sz = maxsz;
        if (ib < 1) ib = 1;
        if (ib - 1 > sz - 2) ib = sz - 1;
        return int'(ib - 1);
    endfunction

    task automatic send(input logic c, input logic [bis_pkg::COORD_W-1:0] x,
                        input logic [bis_pkg::COORD_W-1:0] y,
                        input logic [bis_pkg::PIX_W-1:0] p);
        int g;
        @(negedge i_clk);
        in_valid <= 1'b1;
        cmd      <= c;
        col      <= x;
        row      <= y;
        pix      <= p;
        do @(posedge i_clk); while (!in_ready);
        if (c == bis_pkg::CMD_REQ) req_sent++;
        else if (x < MAXW && y < MAXH) written[int'(y)*MAXW + int'(x)] = 1'b1;
        g = gap_draw();
        if (g > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [bis_pkg::PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return bis_pkg::PIX_W'($urandom);
        endcase
    endfunction

    // request a destination pixel, loading any neighbor not yet written
    task automatic request(input logic [bis_pkg::COORD_W-1:0] x,
                           input logic [bis_pkg::COORD_W-1:0] y);
        int sx, sy, a;
        sx = src_index(x, cur_sx, cur_w, MAXW);
        sy = src_index(y, cur_sy, cur_h, MAXH);
        for (int k = 0; k < 4; k++) begin
            a = (sy + k / 2) * MAXW + sx + k % 2;
            if (!written[a])
                send(bis_pkg::CMD_LOAD, bis_pkg::COORD_W'(sx + k % 2),
                     bis_pkg::COORD_W'(sy + k / 2), pick_pixel());
        end
        send(bis_pkg::CMD_REQ, x, y, bis_pkg::PIX_W'($urandom));
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (req_sent != res_got) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input bis_pkg::t_cfg_idx idx,
                             input logic [bis_pkg::CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            bis_pkg::CFG_SRC_WIDTH:  cur_w  = d[bis_pkg::SIZE_W-1:0];
            bis_pkg::CFG_SRC_HEIGHT: cur_h  = d[bis_pkg::SIZE_W-1:0];
            bis_pkg::CFG_STEP_X:     cur_sx = d;
            bis_pkg::CFG_STEP_Y:     cur_sy = d;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(input int w, input int h, input int sx, input int sy);
        write_reg(bis_pkg::CFG_SRC_WIDTH,  {10'($urandom), bis_pkg::SIZE_W'(w)});
        write_reg(bis_pkg::CFG_SRC_HEIGHT, {10'($urandom), bis_pkg::SIZE_W'(h)});
        write_reg(bis_pkg::CFG_STEP_X, bis_pkg::STEP_W'(sx));
        write_reg(bis_pkg::CFG_STEP_Y, bis_pkg::STEP_W'(sy));
    endtask

    function automatic logic [bis_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return bis_pkg::COORD_W'($urandom);
            1:       return bis_pkg::COORD_W'($urandom_range(0, 15));
            default: return bis_pkg::COORD_W'($urandom_range(0, 200));
        endcase
    endfunction

    initial begin
        int w, h, sx, sy;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, extreme pixels, corner coordinates
        calm = 1'b1;
        send(bis_pkg::CMD_LOAD, 12'd0, 12'd0, 8'd255);
        send(bis_pkg::CMD_LOAD, 12'd1, 12'd0, 8'd0);
        send(bis_pkg::CMD_LOAD, 12'd0, 12'd1, 8'd255);
        send(bis_pkg::CMD_LOAD, 12'd1, 12'd1, 8'd255);
        send(bis_pkg::CMD_LOAD, 12'd4095, 12'd4095, 8'd77);  // outside the store: ignored
        send(bis_pkg::CMD_LOAD, 12'd511, 12'd4095, 8'd12);
        request(12'd0, 12'd0);
        request(12'd4095, 12'd0);
        request(12'd0, 12'd4095);
        request(12'd4095, 12'd4095);
        drain();
        setup(2, 2, 1, 1);
        request(12'd0, 12'd0);
        request(12'd4095, 12'd4095);
        drain();
        setup(0, 1023, 0, 0);               // sizes clamp, zero step
        request(12'd0, 12'd0);
        request(12'd17, 12'd4095);
        drain();
        setup(512, 512, 20'hFFFFF, 20'hFFFFF);
        request(12'd0, 12'd0);
        request(12'd1, 12'd1);
        request(12'd4095, 12'd4095);
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph % 3 == 1);
            case ($urandom_range(0, 2))
                0: begin w = $urandom_range(2, 16); h = $urandom_range(2, 16); end
                1: begin w = $urandom_range(0, 1023); h = $urandom_range(0, 1023); end
                default: begin w = $urandom_range(2, 64); h = $urandom_range(2, 64); end
            endcase
            sx = ($urandom_range(0, 1) == 1) ? $urandom_range(1 << 14, 1 << 18)
                                              : $urandom_range(0, 20'hFFFFF);
            sy = ($urandom_range(0, 1) == 1) ? $urandom_range(1 << 14, 1 << 18)
                                              : $urandom_range(0, 20'hFFFFF);
            setup(w, h, sx, sy);
            for (int n = 0; n < 120; n++) begin
                if ($urandom_range(0, 9) < 7) request(pick_coord(), pick_coord());
                else if ($urandom_range(0, 4) == 0)
                    send(bis_pkg::CMD_LOAD, bis_pkg::COORD_W'($urandom),
                         bis_pkg::COORD_W'($urandom), bis_pkg::PIX_W'($urandom));
                else
                    send(bis_pkg::CMD_LOAD, bis_pkg::COORD_W'($urandom_range(0, 63)),
                         bis_pkg::COORD_W'($urandom_range(0, 63)), pick_pixel());
                if (n == 60) drain();
            end
            drain();
        end

        if (fails == 0 && pending == 0) begin
            $display("[bilinear_image_scaler] OK");
        end else begin
            $display("[bilinear_image_scaler] ERROR");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("[bilinear_image_scaler] ERROR");
        $finish;
    end

endmodule
